@@ hw/rtl/rpwm_pkg.sv @@
// Shared types and constants for the RGB PWM block with serial command parser.
// Used by every module in hw/rtl; depends on nothing.

package rpwm_pkg;

  localparam int PWM_BITS_DEFAULT = 8;

  // Command bytes
  localparam logic [7:0] CH_START  = 8'h3C;  // '<'
  localparam logic [7:0] CH_END    = 8'h3E;  // '>'
  localparam logic [7:0] CH_SELECT = 8'h63;  // 'c'
  localparam logic [7:0] CH_WRITE  = 8'h77;  // 'w'

  localparam logic [7:0] NUM_CHAN_MAX = 8'd3;

  // Reset values
  localparam logic [7:0] DUTY_RED_RESET   = 8'd250;
  localparam logic [7:0] DUTY_GREEN_RESET = 8'd125;
  localparam logic [7:0] DUTY_BLUE_RESET  = 8'd40;
  localparam logic [1:0] CHAN_RESET       = 2'd1;

  // Channel codes
  localparam logic [1:0] CHAN_NONE  = 2'd0;
  localparam logic [1:0] CHAN_RED   = 2'd1;
  localparam logic [1:0] CHAN_GREEN = 2'd2;
  localparam logic [1:0] CHAN_BLUE  = 2'd3;

  typedef logic [2:0][7:0] duty_arr_t;  // [0] red, [1] green, [2] blue

  typedef struct packed {
    logic       command;       // 0 tick, 1 serial byte
    logic [7:0] rx_byte;
    logic       uart_pending;
  } in_item_t;

  typedef struct packed {
    logic       pin_red;
    logic       pin_green;
    logic       pin_blue;
    logic [7:0] pwm_count;
    logic       receiving;
    logic [1:0] selected_channel;
    logic [7:0] duty_red;
    logic [7:0] duty_green;
    logic [7:0] duty_blue;
  } out_item_t;

  // Work issued to the state modules for one request
  typedef struct packed {
    logic     step;
    in_item_t item;
  } step_t;

endpackage

@@ hw/rtl/rpwm_parser.sv @@
// Serial command parser: frame phase, held number, selected channel, duties
// and the receiving flag. Depends on rpwm_pkg.

module rpwm_parser import rpwm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  step_t      req,
  output logic       recv_next,
  output logic [1:0] chan_next,
  output duty_arr_t  duty_next
);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_NUMBER = 2'd1,
    PH_CMD    = 2'd2
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] held, held_next;
  logic       recv;
  logic [1:0] chan;
  duty_arr_t  duty;

  always_comb begin
    phase_next = phase;
    held_next  = held;
    recv_next  = recv;
    chan_next  = chan;
    duty_next  = duty;
    if (req.item.command) begin
      case (phase)
        PH_NUMBER: begin
          held_next  = req.item.rx_byte;
          phase_next = PH_CMD;
        end
        PH_CMD: begin
          if (req.item.rx_byte == CH_SELECT) begin
            if (held <= NUM_CHAN_MAX) begin
              chan_next = held[1:0];
            end
          end else if (req.item.rx_byte == CH_WRITE) begin
            case (chan)
              CHAN_RED:   duty_next[0] = held;
              CHAN_GREEN: duty_next[1] = held;
              CHAN_BLUE:  duty_next[2] = held;
              default:    ;  // no channel selected: drop the write
            endcase
          end
          phase_next = PH_IDLE;
        end
        default: begin
          phase_next = PH_IDLE;
          if (req.item.rx_byte == CH_START) begin
            phase_next = PH_NUMBER;
          end else if (req.item.rx_byte == CH_END) begin
            recv_next = 1'b0;
          end
        end
      endcase
    end else if (req.item.uart_pending) begin
      recv_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      held  <= 8'd0;
      recv  <= 1'b0;
      chan  <= CHAN_RESET;
      duty  <= {DUTY_BLUE_RESET, DUTY_GREEN_RESET, DUTY_RED_RESET};
    end else if (req.step) begin
      phase <= phase_next;
      held  <= held_next;
      recv  <= recv_next;
      chan  <= chan_next;
      duty  <= duty_next;
    end
  end

endmodule

@@ hw/rtl/rpwm_gen.sv @@
// PWM counter and pin compare for the three channels.
// Depends on rpwm_pkg; duties come from rpwm_parser.

module rpwm_gen import rpwm_pkg::*; #(
  parameter int PWM_BITS = PWM_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  step_t      req,
  input  duty_arr_t  duty,
  output logic [7:0] count_low_next,
  output logic [2:0] pins_next
);

  localparam int CMP_W = (PWM_BITS > 8) ? PWM_BITS : 8;

  logic [PWM_BITS-1:0] count, count_next;
  logic [2:0]          pins;
  logic [CMP_W-1:0]    count_ext;

  assign count_ext      = CMP_W'(count_next);
  assign count_low_next = count_ext[7:0];

  always_comb begin
    count_next = count;
    pins_next  = pins;
    if (!req.item.command) begin
      count_next = count + PWM_BITS'(1);
      // pending serial data holds the pins
      if (!req.item.uart_pending) begin
        for (int i = 0; i < 3; i++) begin
          pins_next[i] = (CMP_W'(count_next) < CMP_W'(duty[i]));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pins  <= 3'b000;
    end else if (req.step) begin
      count <= count_next;
      pins  <= pins_next;
    end
  end

endmodule

@@ hw/rtl/rpwm_out_buf.sv @@
// Two-entry result buffer (output register plus skid entry).
// Depends on rpwm_pkg for the result type.

module rpwm_out_buf import rpwm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_item_t push_data,
  output logic      ready,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      skid_valid;
  out_item_t skid_data;
  logic      take;

  assign take  = out_valid && !out_stall;
  assign ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (push) begin
        if (!out_valid || take) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (take) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (!out_valid || take) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end else if (take && skid_valid) begin
      out_data <= skid_data;
    end
  end

endmodule

@@ hw/rtl/rgb_pwm_with_uart_commands_top.sv @@
// Three-channel RGB PWM with a serial byte-command parser: one result per request,
// a new request accepted every cycle while in_stall is low. A request passes the
// input register, then its state update is stored in the two-entry result buffer.
// On a consumer stall that buffer fills and in_stall rises until a result is taken.
// Depends on rpwm_pkg, rpwm_parser, rpwm_gen and rpwm_out_buf.

module rgb_pwm_with_uart_commands_top import rpwm_pkg::*; #(
  parameter int PWM_BITS = PWM_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic       req_valid;
  in_item_t   req_item;
  logic       buf_ready;
  step_t      req;
  logic       recv_next;
  logic [1:0] chan_next;
  duty_arr_t  duty_next;
  logic [7:0] count_low_next;
  logic [2:0] pins_next;
  out_item_t  result;

  assign req.step = req_valid && buf_ready;
  assign req.item = req_item;
  assign in_stall = req_valid && !buf_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_item <= in_data;
    end
  end

  rpwm_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .recv_next (recv_next),
    .chan_next (chan_next),
    .duty_next (duty_next)
  );

  rpwm_gen #(
    .PWM_BITS (PWM_BITS)
  ) u_gen (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .duty           (duty_next),
    .count_low_next (count_low_next),
    .pins_next      (pins_next)
  );

  always_comb begin
    result.pin_red          = pins_next[0];
    result.pin_green        = pins_next[1];
    result.pin_blue         = pins_next[2];
    result.pwm_count        = count_low_next;
    result.receiving        = recv_next;
    result.selected_channel = chan_next;
    result.duty_red         = duty_next[0];
    result.duty_green       = duty_next[1];
    result.duty_blue        = duty_next[2];
  end

  rpwm_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (req.step),
    .push_data (result),
    .ready     (buf_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for rgb_pwm_with_uart_commands_top: a scoreboard class predicts
// every result from the accepted requests, and plain tasks drive the valid/stall channels.
// Depends on rpwm_pkg and the RTL under hw/rtl.
`timescale 1ns / 1ps

module tb_top;
  import rpwm_pkg::*;

  localparam int ITEM_TARGET      = 950;
  localparam int IDLE_MAX         = 10;
  localparam int LONG_HOLD_AT     = 300;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int PAUSE_AT         = 600;
  localparam int DRAIN_CYCLES     = 20;
  localparam logic [7:0] CMD_UNUSED = 8'h71;  // 'q': not a parser command

  typedef enum logic [1:0] {
    WAIT_START,
    GOT_START,
    GOT_NUMBER
  } parse_phase_t;

  class pwm_scoreboard;
    logic [PWM_BITS_DEFAULT-1:0] count;
    duty_arr_t    duty;
    logic [1:0]   chan;
    parse_phase_t phase;
    logic [7:0]   held;
    logic         recv;
    logic [2:0]   pins;
    out_item_t    expected_q[$];
    int errors, ticks, held_ticks, bytes_seen, writes, selects, checked;

    function new();
      count   = '0;
      duty[0] = DUTY_RED_RESET;
      duty[1] = DUTY_GREEN_RESET;
      duty[2] = DUTY_BLUE_RESET;
      chan    = CHAN_RESET;
      phase   = WAIT_START;
      held    = '0;
      recv    = 1'b0;
      pins    = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Update the predicted state for one accepted request and queue its result.
    function void note_request(in_item_t it);
      out_item_t exp;
      if (it.command) begin
        bytes_seen++;
        case (phase)
          GOT_START: begin
            held  = it.rx_byte;
            phase = GOT_NUMBER;
          end
          GOT_NUMBER: begin
            if (it.rx_byte == CH_SELECT && held <= NUM_CHAN_MAX) begin
              chan = held[1:0];
              selects++;
            end else if (it.rx_byte == CH_WRITE && chan != CHAN_NONE) begin
              duty[chan - 2'd1] = held;
              writes++;
            end
            phase = WAIT_START;
          end
          default: begin
            phase = WAIT_START;
            if (it.rx_byte == CH_START) phase = GOT_START;
            else if (it.rx_byte == CH_END) recv = 1'b0;
          end
        endcase
      end else begin
        ticks++;
        count = count + 1'b1;
        if (it.uart_pending) begin
          // hold the pins while serial data waits
          recv = 1'b1;
          held_ticks++;
        end else begin
          for (int i = 0; i < 3; i++) pins[i] = (count < duty[i]);
        end
      end
      exp.pin_red          = pins[0];
      exp.pin_green        = pins[1];
      exp.pin_blue         = pins[2];
      exp.pwm_count        = 8'(count);
      exp.receiving        = recv;
      exp.selected_channel = chan;
      exp.duty_red         = duty[0];
      exp.duty_green       = duty[1];
      exp.duty_blue        = duty[2];
      expected_q.push_back(exp);
    endfunction

    function void field_check(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      checked++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: got %h", $time, got);
        return;
      end
      exp = expected_q.pop_front();
      field_check("pin_red", exp.pin_red, got.pin_red);
      field_check("pin_green", exp.pin_green, got.pin_green);
      field_check("pin_blue", exp.pin_blue, got.pin_blue);
      field_check("pwm_count", exp.pwm_count, got.pwm_count);
      field_check("receiving", exp.receiving, got.receiving);
      field_check("selected_channel", exp.selected_channel, got.selected_channel);
      field_check("duty_red", exp.duty_red, got.duty_red);
      field_check("duty_green", exp.duty_green, got.duty_green);
      field_check("duty_blue", exp.duty_blue, got.duty_blue);
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  pwm_scoreboard sb = new();
  bit idle_on = 1'b1;
  int sent;

  always #5 clk = ~clk;

  rgb_pwm_with_uart_commands_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  function automatic in_item_t tick(logic pend);
    in_item_t it;
    it.command      = 1'b0;
    it.rx_byte      = 8'($urandom_range(0, 255));
    it.uart_pending = pend;
    return it;
  endfunction

  function automatic in_item_t serial(logic [7:0] b);
    in_item_t it;
    it.command      = 1'b1;
    it.rx_byte      = b;
    it.uart_pending = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Keep valid high across back-to-back requests; lower it only for a gap.
  task automatic send_request(input in_item_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_request(it);
    sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin : result_sink
    int n;
    while (rst) @(posedge clk);
    forever begin
      n = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
      // long hold-off so the result buffer fills and the input backs up
      if (sb.checked == LONG_HOLD_AT) n = LONG_HOLD_CYCLES;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_data);
    end
  end

  initial begin : stimulus
    in_item_t directed_q[$];
    logic [7:0] num;
    logic [7:0] cmd;
    int kind;
    int burst;
    bit paused;

    directed_q = '{
      tick(1'b0), tick(1'b1),
      // '>' as the number byte must not clear receiving; select above three
      serial(CH_START), serial(CH_END), serial(CH_SELECT),
      serial(CH_END),
      serial(CH_START), serial({6'd0, CHAN_NONE}), serial(CH_SELECT),
      serial(CH_START), serial(8'hFF), serial(CH_WRITE),
      serial(CH_START), serial({6'd0, CHAN_BLUE}), serial(CH_SELECT),
      serial(CH_START), serial(8'hFF), serial(CH_WRITE),
      serial(CH_START), serial(8'h00), serial(CH_WRITE),
      serial(CH_START), serial(8'd5), serial(CMD_UNUSED),
      tick(1'b0)
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_q[i]) send_request(directed_q[i]);
    wait_drained();

    paused = 1'b0;
    while (sent < ITEM_TARGET) begin
      idle_on = ((sent / 150) % 3) != 2;
      if (!paused && sent >= PAUSE_AT) begin
        wait_drained();
        paused = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        num = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 5))
                                         : 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
          0, 1, 2, 3: cmd = CH_SELECT;
          4, 5, 6, 7: cmd = CH_WRITE;
          default:    cmd = 8'($urandom_range(0, 255));
        endcase
        send_request(serial(CH_START));
        if ($urandom_range(0, 4) == 0) send_request(tick(1'($urandom_range(0, 1))));
        send_request(serial(num));
        if ($urandom_range(0, 4) == 0) send_request(tick(1'($urandom_range(0, 1))));
        send_request(serial(cmd));
      end else if (kind < 80) begin
        burst = $urandom_range(1, 16);
        repeat (burst) send_request(tick($urandom_range(0, 5) == 0));
      end else if (kind < 92) begin
        send_request(serial(($urandom_range(0, 2) == 0) ? CH_END
                                                        : 8'($urandom_range(0, 255))));
      end else begin
        // frame left open or filled with delimiter bytes
        send_request(serial(CH_START));
        case ($urandom_range(0, 2))
          0:       send_request(serial(CH_START));
          1:       send_request(serial(CH_END));
          default: send_request(serial(8'($urandom_range(0, 255))));
        endcase
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests: %0d ticks (%0d with UART pending), %0d serial bytes,",
             sent, sb.ticks, sb.held_ticks, sb.bytes_seen);
    $display("%0d duty writes, %0d channel selects, %0d results checked, %0d mismatches.",
             sb.writes, sb.selects, sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Timeout with %0d results outstanding", sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
